// ===== hdl/kmd_pkg.sv =====
// ----------------------------------------------------------------------------
// Key matrix debounce package
// Shared widths, register codes, reset values and transfer structs.
// ----------------------------------------------------------------------------
package kmd_pkg;

    localparam int ROW_COUNT_DEF = 4;
    localparam int COL_COUNT_DEF = 4;

    localparam int ROW_W      = 2;
    localparam int COL_W      = 2;
    localparam int CNT_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CNT_W-1:0]  DEBOUNCE_MAX = 4'd14;
    localparam logic [CNT_W-1:0]  DEBOUNCE_RST = 4'd5;
    localparam logic [NOTE_W-1:0] BASE_NOTE_RST = 7'h24;
    localparam logic [BYTE_W-1:0] STATUS_RST = 8'h90;
    localparam logic [VEL_W-1:0]  VELOCITY_RST = 7'h45;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE  = 2'd0,
        REG_BASE_NOTE = 2'd1,
        REG_STATUS    = 2'd2,
        REG_VELOCITY  = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        BYTE_STATUS   = 2'd0,
        BYTE_NOTE     = 2'd1,
        BYTE_VELOCITY = 2'd2
    } t_byte_sel;

    typedef struct packed {
        logic [CNT_W-1:0]  debounce;
        logic [NOTE_W-1:0] base_note;
        logic [BYTE_W-1:0] status;
        logic [VEL_W-1:0]  velocity;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] status;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
    } t_msg;

    function automatic int idx_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== hdl/kmd_intf.sv =====
// ----------------------------------------------------------------------------
// Key matrix debounce channel interfaces
// Key scan input, MIDI byte output and register write channels.
// ----------------------------------------------------------------------------
interface kmd_key_if import kmd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] key_row;
    logic [COL_W-1:0] key_col;
    logic             pressed;

    modport source (output valid, output key_row, output key_col, output pressed,
                    input ready);
    modport sink   (input valid, input key_row, input key_col, input pressed,
                    output ready);
endinterface

interface kmd_midi_if import kmd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] midi_byte;
    logic              last_byte;

    modport source (output valid, output midi_byte, output last_byte, input ready);
    modport sink   (input valid, input midi_byte, input last_byte, output ready);
endinterface

interface kmd_cfg_if import kmd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== hdl/kmd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module kmd_ram import kmd_pkg::*; #(
    parameter int WIDTH = CNT_W,
    parameter int DEPTH = ROW_COUNT_DEF * COL_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [idx_width(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]            i_wdata,
    input  logic                        i_re,
    input  logic [idx_width(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]            o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/kmd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Key matrix debounce configuration registers
// Decode register writes; clamp the debounce count to its legal maximum.
// ----------------------------------------------------------------------------
module kmd_cfg_regs import kmd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kmd_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg             r_cfg;
    logic [CNT_W-1:0] wr_count;

    assign i_cfg.ready = 1'b1;
    assign wr_count    = i_cfg.wr_data[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce  <= DEBOUNCE_RST;
            r_cfg.base_note <= BASE_NOTE_RST;
            r_cfg.status    <= STATUS_RST;
            r_cfg.velocity  <= VELOCITY_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_reg_idx'(i_cfg.reg_index))
                REG_DEBOUNCE: begin
                    r_cfg.debounce <= (wr_count > DEBOUNCE_MAX) ? DEBOUNCE_MAX : wr_count;
                end
                REG_BASE_NOTE: begin
                    r_cfg.base_note <= i_cfg.wr_data[NOTE_W-1:0];
                end
                REG_STATUS: begin
                    r_cfg.status <= i_cfg.wr_data[BYTE_W-1:0];
                end
                REG_VELOCITY: begin
                    r_cfg.velocity <= i_cfg.wr_data[VEL_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/kmd_core.sv =====
// ----------------------------------------------------------------------------
// Key matrix debounce core
// Read the key counter from RAM, update it, write it back, build the message.
// ----------------------------------------------------------------------------
module kmd_core import kmd_pkg::*; #(
    parameter int ROW_COUNT = ROW_COUNT_DEF,
    parameter int COL_COUNT = COL_COUNT_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    kmd_key_if.sink i_key,
    input  t_cfg    i_cfg,
    input  logic    i_tx_free,
    output logic    o_tx_load,
    output t_msg    o_tx_msg
);

    localparam int KEY_TOTAL = ROW_COUNT * COL_COUNT;
    localparam int IDX_W     = idx_width(KEY_TOTAL);
    localparam int LIN_W     = 8;
    localparam int DIM_W     = 5;
    localparam int SUM_W     = ((IDX_W > NOTE_W) ? IDX_W : NOTE_W) + 1;

    logic                 in_fire;
    logic                 in_hit;
    logic [LIN_W-1:0]     in_lin;
    logic [IDX_W-1:0]     in_idx;

    logic                 r_s1_valid;
    logic [IDX_W-1:0]     r_s1_idx;
    logic                 r_s1_pressed;
    logic [KEY_TOTAL-1:0] r_key_valid;
    logic                 r_fwd_valid;
    logic [IDX_W-1:0]     r_fwd_idx;
    logic [CNT_W-1:0]     r_fwd_cnt;

    logic [CNT_W-1:0]     ram_q;
    logic [CNT_W-1:0]     cnt_old;
    logic [CNT_W-1:0]     cnt_upd;
    logic [CNT_W-1:0]     n_cnt;
    logic                 s1_on;
    logic                 s1_emit;
    logic                 s1_fire;
    logic [SUM_W-1:0]     note_sum;

    assign in_hit = (DIM_W'(i_key.key_row) < DIM_W'(ROW_COUNT))
                 && (DIM_W'(i_key.key_col) < DIM_W'(COL_COUNT));
    assign in_lin = LIN_W'(i_key.key_row) * LIN_W'(COL_COUNT) + LIN_W'(i_key.key_col);
    assign in_idx = IDX_W'(in_lin);

    assign in_fire     = i_key.valid && i_key.ready;
    assign i_key.ready = !r_s1_valid || s1_fire;

    kmd_ram #(
        .WIDTH (CNT_W),
        .DEPTH (KEY_TOTAL)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_idx),
        .i_wdata (n_cnt),
        .i_re    (in_fire && in_hit),
        .i_raddr (in_idx),
        .o_rdata (ram_q)
    );

    always_comb begin
        if (r_fwd_valid && (r_fwd_idx == r_s1_idx)) begin
            cnt_old = r_fwd_cnt;
        end else if (r_key_valid[r_s1_idx]) begin
            cnt_old = ram_q;
        end else begin
            cnt_old = '0;
        end

        if (r_s1_pressed) begin
            cnt_upd = (cnt_old < i_cfg.debounce) ? cnt_old + CNT_W'(1) : cnt_old;
        end else begin
            cnt_upd = '0;
        end

        s1_on   = (cnt_upd == i_cfg.debounce);
        n_cnt   = s1_on ? cnt_upd + CNT_W'(1) : cnt_upd;
        s1_emit = s1_on || (cnt_upd == '0);
    end

    assign s1_fire   = r_s1_valid && (!s1_emit || i_tx_free);
    assign o_tx_load = s1_fire && s1_emit;

    assign note_sum          = SUM_W'(i_cfg.base_note) + SUM_W'(r_s1_idx);
    assign o_tx_msg.status   = i_cfg.status;
    assign o_tx_msg.note     = note_sum[NOTE_W-1:0];
    assign o_tx_msg.velocity = s1_on ? i_cfg.velocity : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_key_valid <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= in_hit;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_fwd_valid           <= 1'b1;
                r_key_valid[r_s1_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_idx     <= in_idx;
            r_s1_pressed <= i_key.pressed;
        end
        if (s1_fire) begin
            r_fwd_idx <= r_s1_idx;
            r_fwd_cnt <= n_cnt;
        end
    end

endmodule

// ===== hdl/kmd_tx.sv =====
// ----------------------------------------------------------------------------
// Key matrix debounce message serializer
// Hold one three-byte message and send it one byte per transfer.
// ----------------------------------------------------------------------------
module kmd_tx import kmd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_msg       i_msg,
    output logic       o_free,
    kmd_midi_if.source o_midi
);

    t_msg      r_msg;
    logic      r_valid;
    t_byte_sel r_sel;
    t_byte_sel n_sel;
    logic      xfer;
    logic      done;

    assign xfer   = r_valid && o_midi.ready;
    assign done   = xfer && (r_sel == BYTE_VELOCITY);
    assign o_free = !r_valid || done;

    always_comb begin
        unique case (r_sel)
            BYTE_STATUS: n_sel = BYTE_NOTE;
            BYTE_NOTE:   n_sel = BYTE_VELOCITY;
            default:     n_sel = BYTE_STATUS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= BYTE_STATUS;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_sel   <= BYTE_STATUS;
        end else if (done) begin
            r_valid <= 1'b0;
            r_sel   <= BYTE_STATUS;
        end else if (xfer) begin
            r_sel <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_msg <= i_msg;
        end
    end

    always_comb begin
        unique case (r_sel)
            BYTE_STATUS:   o_midi.midi_byte = r_msg.status;
            BYTE_NOTE:     o_midi.midi_byte = BYTE_W'(r_msg.note);
            BYTE_VELOCITY: o_midi.midi_byte = BYTE_W'(r_msg.velocity);
            default:       o_midi.midi_byte = '0;
        endcase
    end

    assign o_midi.valid     = r_valid;
    assign o_midi.last_byte = (r_sel == BYTE_VELOCITY);

endmodule

// ===== hdl/key_matrix_debounce_midi_notes.sv =====
// ----------------------------------------------------------------------------
// Key matrix debounce to MIDI notes
// Per-key counter debounce that emits three-byte MIDI note messages.
//
// i_key takes one scan sample per transfer: row, column and pressed flag.
// Samples outside the ROW_COUNT x COL_COUNT matrix are taken and dropped.
// o_midi sends status, note and velocity bytes; last_byte marks velocity.
// i_cfg writes debounce count, base note, status byte and press velocity;
// write only while no message is in flight.
// A sample is taken every cycle unless a held sample waits to send; the
// counter RAM is read in the cycle of the transfer, updated in stage one
// and written back, with the last write forwarded when the next sample
// hits the same key. Messages pass from stage one into the serializer.
// Silent samples sustain one per cycle; a sample that sends a message
// waits until the one-byte-per-transfer output register is free.
// Reset loads register defaults and marks every counter as zero at once
// through per-key valid bits; no clearing pass.
// When o_midi stalls, the held message waits and i_key backs up after
// one more sample that needs to send.
// ----------------------------------------------------------------------------
module key_matrix_debounce_midi_notes import kmd_pkg::*; #(
    parameter int ROW_COUNT = ROW_COUNT_DEF,
    parameter int COL_COUNT = COL_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kmd_key_if.sink    i_key,
    kmd_cfg_if.sink    i_cfg,
    kmd_midi_if.source o_midi
);

    t_cfg cfg;
    t_msg tx_msg;
    logic tx_load;
    logic tx_free;

    kmd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    kmd_core #(
        .ROW_COUNT (ROW_COUNT),
        .COL_COUNT (COL_COUNT)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (i_key),
        .i_cfg     (cfg),
        .i_tx_free (tx_free),
        .o_tx_load (tx_load),
        .o_tx_msg  (tx_msg)
    );

    kmd_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (tx_load),
        .i_msg   (tx_msg),
        .o_free  (tx_free),
        .o_midi  (o_midi)
    );

endmodule
